[rtl/vfm_pkg.sv]
// vfm_pkg: shared types, constants and face tables for the voxel face mesher.
// No dependencies.
`default_nettype none
package vfm_pkg;
    localparam int DEF_SIZE_X = 16;
    localparam int DEF_SIZE_Y = 128;
    localparam int DEF_SIZE_Z = 16;

    localparam logic [1:0] FUNC_WCELL  = 2'd0;
    localparam logic [1:0] FUNC_WBORD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] REG_AIR   = 2'd0;
    localparam logic [1:0] REG_UNDEF = 2'd1;
    localparam logic [1:0] REG_GRASS = 2'd2;
    localparam logic [1:0] REG_NBR   = 2'd3;

    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_BACK   = 3'd1;
    localparam logic [2:0] FACE_LEFT   = 3'd2;
    localparam logic [2:0] FACE_RIGHT  = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_EVAL,
        BK_EMIT
    } bk_state_t;

    // request handed from front to back
    typedef struct packed {
        logic [1:0] func;
        logic [3:0] x;
        logic [6:0] y;
        logic [3:0] z;
        logic [1:0] side;
        logic [7:0] bt;
    } vfm_item_t;

    // corner offsets and uv: {dx,dy,dz,u,v}
    function automatic logic [4:0] face_vert(input logic [2:0] f, input logic [2:0] v);
        logic [4:0] r;
        r = 5'd0;
        case (f)
            3'd0: case (v)
                3'd0, 3'd5: r = 5'b11111;
                3'd1: r = 5'b01101;
                3'd2, 3'd3: r = 5'b00100;
                default: r = 5'b10110;
            endcase
            3'd1: case (v)
                3'd0, 3'd5: r = 5'b01011;
                3'd1: r = 5'b11001;
                3'd2, 3'd3: r = 5'b10000;
                default: r = 5'b00010;
            endcase
            3'd2: case (v)
                3'd0, 3'd5: r = 5'b01111;
                3'd1: r = 5'b01001;
                3'd2, 3'd3: r = 5'b00000;
                default: r = 5'b00110;
            endcase
            3'd3: case (v)
                3'd0, 3'd5: r = 5'b11011;
                3'd1: r = 5'b11101;
                3'd2, 3'd3: r = 5'b10100;
                default: r = 5'b10010;
            endcase
            3'd4: case (v)
                3'd0, 3'd5: r = 5'b11011;
                3'd1: r = 5'b01001;
                3'd2, 3'd3: r = 5'b01100;
                default: r = 5'b11110;
            endcase
            default: case (v)
                3'd0, 3'd5: r = 5'b00011;
                3'd1: r = 5'b10001;
                3'd2, 3'd3: r = 5'b10100;
                default: r = 5'b00110;
            endcase
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/vfm_if.sv]
// vfm_if: valid/ready channel interfaces for requests, vertices and config writes.
// No dependencies.
`default_nettype none
interface vfm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] cell_x;
    logic [6:0] cell_y;
    logic [3:0] cell_z;
    logic [1:0] border_side;
    logic [7:0] block_type;
    modport source (output valid, func, cell_x, cell_y, cell_z, border_side, block_type,
                    input ready);
    modport sink (input valid, func, cell_x, cell_y, cell_z, border_side, block_type,
                  output ready);
endinterface

interface vfm_vert_if;
    logic       valid;
    logic       ready;
    logic [4:0] vert_x;
    logic [7:0] vert_y;
    logic [4:0] vert_z;
    logic [2:0] face_id;
    logic       tex_u;
    logic       tex_v;
    logic [7:0] tex_layer;
    logic       last;
    modport source (output valid, vert_x, vert_y, vert_z, face_id, tex_u, tex_v,
                    tex_layer, last, input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, face_id, tex_u, tex_v,
                  tex_layer, last, output ready);
endinterface

interface vfm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/vfm_ram.sv]
// vfm_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module vfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[rtl/vfm_front.sv]
// vfm_front: accepts requests, drops unused/out-of-range ones, queues the rest.
// Depends on vfm_pkg.
`default_nettype none
module vfm_front #(
    parameter int SIZE_X = vfm_pkg::DEF_SIZE_X,
    parameter int SIZE_Y = vfm_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z = vfm_pkg::DEF_SIZE_Z
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    vfm_req_if.sink                req,
    output logic                   q_valid,
    output vfm_pkg::vfm_item_t     q_item,
    input  wire logic              q_pop
);
    localparam int QD = 2;
    vfm_pkg::vfm_item_t buf_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    vfm_pkg::vfm_item_t it;
    logic keep, push;
    logic [4:0] a;
    logic [6:0] lim;

    always_comb
    begin
        it.func = req.func;
        it.x    = req.cell_x;
        it.y    = req.cell_y;
        it.z    = req.cell_z;
        it.side = req.border_side;
        it.bt   = req.block_type;
        a   = req.border_side[1] ? {1'b0, req.cell_z} : {1'b0, req.cell_x};
        lim = req.border_side[1] ? 7'(SIZE_Z) : 7'(SIZE_X);
        unique case (req.func)
            vfm_pkg::FUNC_WBORD:
                keep = (9'(req.cell_y) < 9'(SIZE_Y)) && (7'(a) < lim);
            vfm_pkg::FUNC_WCELL, vfm_pkg::FUNC_QUERY:
                keep = (7'(req.cell_x) < 7'(SIZE_X)) && (9'(req.cell_y) < 9'(SIZE_Y))
                       && (7'(req.cell_z) < 7'(SIZE_Z));
            default: keep = 1'b0;
        endcase
    end

    assign req.ready = (cnt_reg != 2'(QD));
    assign push      = req.valid && req.ready && keep;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= it;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");
endmodule
`default_nettype wire

[rtl/vfm_back.sv]
// vfm_back: performs writes and queries; reads seven cells serially, emits vertices.
// Depends on vfm_pkg and vfm_ram.
`default_nettype none
module vfm_back #(
    parameter int SIZE_X = vfm_pkg::DEF_SIZE_X,
    parameter int SIZE_Y = vfm_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z = vfm_pkg::DEF_SIZE_Z
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  vfm_pkg::vfm_item_t q_item,
    output logic               q_pop,
    vfm_cfg_if.sink            cfg,
    vfm_vert_if.source         vout
);
    localparam int BWD = (SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z;
    localparam int AW = $clog2(BWD);
    localparam int CD = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int BD = 4 * SIZE_Y * BWD;
    localparam int CAW = $clog2(CD);
    localparam int BAW = $clog2(BD);

    vfm_pkg::bk_state_t st_reg, st_next;
    vfm_pkg::vfm_item_t it_reg;
    logic [7:0] air_reg, undef_reg, grass_reg;
    logic [3:0] nbr_reg;
    logic [2:0] rd_reg, rd_next;     // read slot: 0 self, 1..6 faces; border side 0..3
    logic [5:0] open_reg;            // neighbor empty per face
    logic [3:0] hide_reg;            // side face covered by neighbor chunk
    logic [7:0] type_reg;
    logic [2:0] f_reg, f_next;
    logic [2:0] v_reg, v_next;
    logic       ov_reg;
    logic [4:0] ox_reg, oz_reg;
    logic [7:0] oy_reg, ol_reg;
    logic [2:0] of_reg;
    logic       ou_reg, ovv_reg, olast_reg;

    logic       c_we, b_we;
    logic [CAW-1:0] c_addr;
    logic [BAW-1:0] b_addr;
    logic [7:0] c_rd;
    logic [0:0] b_rd;
    logic       nb_out;          // neighbour for slot outside chunk
    logic       nb_out_reg;
    logic [2:0] slot_reg;        // slot whose read data arrives now
    logic       rdv_reg;         // read data of slot_reg is valid
    logic       at_edge;
    logic [7:0] nx, nz;
    logic [8:0] ny;
    logic       ld, emit_ok, more;
    logic [5:0] vis, rem;
    logic [4:0] fv;
    logic [2:0] nf;
    logic [1:0] bside;
    logic [AW-1:0] ba;

    vfm_ram #(.WIDTH(8), .DEPTH(CD)) u_cell (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(it_reg.bt), .rdata(c_rd));
    vfm_ram #(.WIDTH(1), .DEPTH(BD)) u_bord (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(it_reg.bt != air_reg), .rdata(b_rd));

    assign cfg.ready = 1'b1;

    // neighbour coordinate of current read slot; border side read alongside
    always_comb
    begin
        nx = {4'd0, it_reg.x};
        ny = {2'd0, it_reg.y};
        nz = {4'd0, it_reg.z};
        case (rd_reg)
            3'd1: nz = nz + 8'd1;
            3'd2: nz = nz - 8'd1;
            3'd3: nx = nx - 8'd1;
            3'd4: nx = nx + 8'd1;
            3'd5: ny = ny + 9'd1;
            3'd6: ny = ny - 9'd1;
            default: ;
        endcase
        nb_out = (nx >= 8'(SIZE_X)) || (ny >= 9'(SIZE_Y)) || (nz >= 8'(SIZE_Z));
        c_addr = CAW'((nx * SIZE_Y + ny) * SIZE_Z + nz);
        bside = (it_reg.func == vfm_pkg::FUNC_WBORD) ? it_reg.side : rd_reg[1:0];
        ba = bside[1] ? AW'(it_reg.z) : AW'(it_reg.x);
        b_addr = BAW'((bside * SIZE_Y + it_reg.y) * BWD + ba);
    end

    // cell on the chunk border of the side whose border bit arrives now
    always_comb
    begin
        case (slot_reg[1:0])
            2'd0:    at_edge = (7'(it_reg.z) == 7'(SIZE_Z - 1));
            2'd1:    at_edge = (it_reg.z == 4'd0);
            2'd2:    at_edge = (it_reg.x == 4'd0);
            default: at_edge = (7'(it_reg.x) == 7'(SIZE_X - 1));
        endcase
    end

    // visible faces from the current one on
    always_comb
    begin
        vis = open_reg & {2'b11, ~hide_reg};
        rem = vis;
        more = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            if (3'(i) < f_reg) rem[i] = 1'b0;
            if (vis[i] && 3'(i) > f_reg) more = 1'b1;
        end
        nf = 3'd6;
        for (int i = 5; i >= 0; i--)
        begin
            if (rem[i]) nf = 3'(i);
        end
        fv = vfm_pkg::face_vert(f_reg, v_reg);
    end

    assign emit_ok = !ov_reg || vout.ready;
    assign ld = (st_reg == vfm_pkg::BK_EMIT) && emit_ok;

    always_comb
    begin
        st_next = st_reg;
        rd_next = rd_reg;
        f_next  = f_reg;
        v_next  = v_reg;
        q_pop   = 1'b0;
        c_we    = 1'b0;
        b_we    = 1'b0;
        unique case (st_reg)
            vfm_pkg::BK_IDLE:
            begin
                f_next = 3'd0;
                v_next = 3'd0;
                if (q_valid) st_next = vfm_pkg::BK_READ;
            end
            vfm_pkg::BK_READ:
            begin
                unique case (it_reg.func)
                    vfm_pkg::FUNC_WCELL:
                    begin
                        c_we = 1'b1;
                        q_pop = 1'b1;
                        st_next = vfm_pkg::BK_IDLE;
                    end
                    vfm_pkg::FUNC_WBORD:
                    begin
                        b_we = 1'b1;
                        q_pop = 1'b1;
                        st_next = vfm_pkg::BK_IDLE;
                    end
                    default:
                    begin
                        rd_next = rd_reg + 3'd1;
                        if (rd_reg == 3'd6) st_next = vfm_pkg::BK_WAIT;
                    end
                endcase
            end
            vfm_pkg::BK_WAIT:
                st_next = vfm_pkg::BK_EVAL;
            vfm_pkg::BK_EVAL:
            begin
                f_next = nf;
                v_next = 3'd0;
                if (nf == 3'd6 || type_reg == air_reg)
                begin
                    q_pop = 1'b1;
                    st_next = vfm_pkg::BK_IDLE;
                end
                else st_next = vfm_pkg::BK_EMIT;
            end
            vfm_pkg::BK_EMIT:
                if (emit_ok)
                begin
                    if (v_reg == 3'd5)
                    begin
                        v_next = 3'd0;
                        f_next = f_reg + 3'd1;
                        st_next = vfm_pkg::BK_EVAL;
                    end
                    else v_next = v_reg + 3'd1;
                end
            default: st_next = vfm_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == vfm_pkg::BK_IDLE && q_valid)
        begin
            it_reg <= q_item;
        end
        slot_reg   <= rd_reg;
        nb_out_reg <= nb_out;
        if (ld)
        begin
            ox_reg    <= 5'({1'b0, it_reg.x} + 5'(fv[4]));
            oy_reg    <= 8'({1'b0, it_reg.y} + 8'(fv[3]));
            oz_reg    <= 5'({1'b0, it_reg.z} + 5'(fv[2]));
            of_reg    <= f_reg;
            ou_reg    <= fv[1];
            ovv_reg   <= fv[0];
            ol_reg    <= (type_reg == grass_reg && f_reg == vfm_pkg::FACE_TOP) ?
                         type_reg + 8'd1 :
                         (type_reg == grass_reg && f_reg == vfm_pkg::FACE_BOTTOM) ?
                         type_reg + 8'd2 : type_reg;
            olast_reg <= (v_reg == 3'd5) && !more;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= vfm_pkg::BK_IDLE;
            rd_reg    <= '0;
            f_reg     <= '0;
            v_reg     <= '0;
            ov_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
            open_reg  <= '0;
            hide_reg  <= '0;
            type_reg  <= '0;
            air_reg   <= 8'd0;
            undef_reg <= 8'd255;
            grass_reg <= 8'd1;
            nbr_reg   <= 4'd0;
        end
        else
        begin
            st_reg <= st_next;
            rd_reg <= (st_next == vfm_pkg::BK_READ) ? rd_next : 3'd0;
            f_reg  <= f_next;
            v_reg  <= v_next;
            if (ld) ov_reg <= 1'b1;
            else if (vout.ready) ov_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    vfm_pkg::REG_AIR:   air_reg   <= cfg.data;
                    vfm_pkg::REG_UNDEF: undef_reg <= cfg.data;
                    vfm_pkg::REG_GRASS: grass_reg <= cfg.data;
                    default:            nbr_reg   <= cfg.data[3:0];
                endcase
            end
            rdv_reg <= (st_reg == vfm_pkg::BK_READ) && (it_reg.func == vfm_pkg::FUNC_QUERY);
            if (rdv_reg)
            begin
                if (slot_reg == 3'd0)
                begin
                    type_reg <= c_rd;
                end
                else
                begin
                    open_reg[slot_reg - 3'd1] <= nb_out_reg || c_rd == air_reg
                                                 || c_rd == undef_reg;
                end
                if (slot_reg < 3'd4)
                begin
                    hide_reg[slot_reg[1:0]] <= nbr_reg[slot_reg[1:0]] && at_edge && b_rd[0];
                end
            end
        end
    end

    assign vout.valid     = ov_reg;
    assign vout.vert_x    = ox_reg;
    assign vout.vert_y    = oy_reg;
    assign vout.vert_z    = oz_reg;
    assign vout.face_id   = of_reg;
    assign vout.tex_u     = ou_reg;
    assign vout.tex_v     = ovv_reg;
    assign vout.tex_layer = ol_reg;
    assign vout.last      = olast_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !vout.ready) |=> ov_reg && $stable(ox_reg))
        else $error("stalled vertex changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        ld |-> f_reg < 3'd6)
        else $error("emit with bad face");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg != vfm_pkg::BK_EMIT)
        else $error("pop during emit");
endmodule
`default_nettype wire

[rtl/voxel_face_mesher.sv]
// voxel_face_mesher: top level, front queue plus back executor.
// Depends on vfm_pkg, vfm_if, vfm_front, vfm_back, vfm_ram.
//
// Usage: requests enter on req (write cell, write border bit, or query).
// Queries that hit a non-air cell return six vertices per exposed face on
// vout, last marks the final vertex. Config registers are written on cfg;
// the user must write them only while idle, the block does not enforce it.
// Operation: a request is registered in the front queue; the back end reads
// the cell and its six neighbours from the cell RAM, one read a cycle, with
// the four border bits read alongside, then emits one vertex per cycle while
// vout is ready. A query handles each exposed face as a face select
// followed by six vertices; the back end finishes one request before it
// takes the next.
// Reset sets control and config registers to defaults; stores are undefined
// until written. A stall on vout holds the vertex register; the two-entry
// front queue keeps accepting until full.
`default_nettype none
module voxel_face_mesher #(
    parameter int SIZE_X = vfm_pkg::DEF_SIZE_X,
    parameter int SIZE_Y = vfm_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z = vfm_pkg::DEF_SIZE_Z
) (
    input wire logic   clk,
    input wire logic   rst_n,
    vfm_req_if.sink    req,
    vfm_cfg_if.sink    cfg,
    vfm_vert_if.source vout
);
    logic               q_valid, q_pop;
    vfm_pkg::vfm_item_t q_item;

    vfm_front #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

    vfm_back #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .cfg(cfg), .vout(vout));
endmodule
`default_nettype wire
